### sv/mm_pkg.sv
// ---------------------------------------------------------------------------
// mm_pkg
// Shared types, codes and helpers for the matrix multiply block.
// ---------------------------------------------------------------------------
package mm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int DIM_W     = 4;   // dimension registers
    localparam int IDX_W     = 3;   // row / column indexes
    localparam int MODE_W    = 2;
    localparam int IN_ELEM_W = 16;  // element field on the input channel
    localparam int PV_W      = 35;  // product_value field
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SUM,
        ST_ERR
    } t_state;

    // Clamp a dimension register into 1..maxv
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

### sv/matrix_multiply.sv
// Loads: load beats stream at one per cycle while the block is idle.
// Compute: for each product element the block issues one store read per cycle
// for each term of clamped cols_a, then the read, multiply and accumulate stages
// finish and the element waits for a free output register; input is held off.
// A dimension error gives its single result beat via the error state.
// Reset: dimension registers go to 8, control clears; the stores are not cleared.
// ---------------------------------------------------------------------------
// matrix_multiply
// General matrix multiply over two element stores held in synchronous RAMs.
// ---------------------------------------------------------------------------
module matrix_multiply #(
    parameter int MaxDim    = mm_pkg::MAX_DIM_DEF,
    parameter int ElemWidth = mm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mm_pkg::MODE_W-1:0]        i_mode,
    input  logic [mm_pkg::IDX_W-1:0]         i_row_index,
    input  logic [mm_pkg::IDX_W-1:0]         i_col_index,
    input  logic signed [mm_pkg::IN_ELEM_W-1:0] i_element,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mm_pkg::IDX_W-1:0]         o_out_row,
    output logic [mm_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [mm_pkg::PV_W-1:0]   o_product_value,
    output logic                             o_last,
    output logic                             o_dim_error,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]         i_cfg_data
);

    localparam int Depth = MaxDim * MaxDim;
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int ProdW = 2 * ElemWidth;
    localparam logic [mm_pkg::DIM_W-1:0] MaxDimV = mm_pkg::DIM_W'(MaxDim);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [mm_pkg::DIM_W-1:0] r_rows_a, r_cols_a, r_rows_b, r_cols_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= mm_pkg::DIM_RESET;
            r_cols_a <= mm_pkg::DIM_RESET;
            r_rows_b <= mm_pkg::DIM_RESET;
            r_cols_b <= mm_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mm_pkg::REG_ROWS_A: r_rows_a <= i_cfg_data;
                mm_pkg::REG_COLS_A: r_cols_a <= i_cfg_data;
                mm_pkg::REG_ROWS_B: r_rows_b <= i_cfg_data;
                mm_pkg::REG_COLS_B: r_cols_b <= i_cfg_data;
            endcase
        end
    end

    // Clamped dims, used live; the user must change configuration only while idle (not enforced)
    logic [mm_pkg::DIM_W-1:0] ra, ca, rb, cb;
    assign ra = mm_pkg::clamp_dim(r_rows_a, MaxDimV);
    assign ca = mm_pkg::clamp_dim(r_cols_a, MaxDimV);
    assign rb = mm_pkg::clamp_dim(r_rows_b, MaxDimV);
    assign cb = mm_pkg::clamp_dim(r_cols_b, MaxDimV);

    // ---------------------------------------------------------------------
    // Input beat decode and store writes
    // ---------------------------------------------------------------------
    mm_pkg::t_state r_state, n_state;

    logic in_fire;
    logic ld_in_range;
    logic we_a, we_b;
    logic is_compute;
    logic [AddrW-1:0] waddr;
    logic signed [47:0] elem_ext;
    logic [ElemWidth-1:0] wdata;

    assign in_fire     = i_in_valid && o_in_ready;
    assign ld_in_range = (int'(i_row_index) < MaxDim) && (int'(i_col_index) < MaxDim);
    assign waddr       = AddrW'(int'(i_row_index) * MaxDim + int'(i_col_index));
    // Sign-extend the 16-bit field, then keep the low ElemWidth bits
    assign elem_ext    = 48'(i_element);
    assign wdata       = elem_ext[ElemWidth-1:0];

    always_comb begin
        we_a       = 1'b0;
        we_b       = 1'b0;
        is_compute = 1'b0;
        unique case (i_mode)
            mm_pkg::MODE_LOAD_A:  we_a = in_fire && ld_in_range;
            mm_pkg::MODE_LOAD_B:  we_b = in_fire && ld_in_range;
            mm_pkg::MODE_COMPUTE: is_compute = 1'b1;
            mm_pkg::MODE_UNUSED:  is_compute = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer counters: r_i row of A, r_j column of B, r_k inner term.
    // Stores are written only while idle and read only during a run, so a
    // read never meets a write to the same entry: no forwarding needed.
    // ---------------------------------------------------------------------
    logic [mm_pkg::IDX_W-1:0] r_i, r_j, r_k;
    logic k_last, j_last, i_last;

    assign k_last = (mm_pkg::DIM_W'(r_k) + mm_pkg::DIM_W'(1)) == ca;
    assign j_last = (mm_pkg::DIM_W'(r_j) + mm_pkg::DIM_W'(1)) == cb;
    assign i_last = (mm_pkg::DIM_W'(r_i) + mm_pkg::DIM_W'(1)) == ra;

    logic [AddrW-1:0] raddr_a, raddr_b;
    assign raddr_a = AddrW'(int'(r_i) * MaxDim + int'(r_k));
    assign raddr_b = AddrW'(int'(r_k) * MaxDim + int'(r_j));

    logic [ElemWidth-1:0] rdata_a, rdata_b;

    mm_ram #(.Width(ElemWidth), .Depth(Depth)) u_a_store (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mm_ram #(.Width(ElemWidth), .Depth(Depth)) u_b_store (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // ---------------------------------------------------------------------
    // State machine: next state
    // ---------------------------------------------------------------------
    logic r_sum_ok;
    logic r_out_valid;
    logic out_free;
    logic issue;
    logic out_load;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mm_pkg::ST_IDLE: begin
                if (in_fire && is_compute) begin
                    n_state = (ca != rb) ? mm_pkg::ST_ERR : mm_pkg::ST_RUN;
                end
            end
            mm_pkg::ST_RUN: begin
                if (k_last) begin
                    n_state = mm_pkg::ST_SUM;
                end
            end
            mm_pkg::ST_SUM: begin
                if (r_sum_ok && out_free) begin
                    n_state = (i_last && j_last) ? mm_pkg::ST_IDLE : mm_pkg::ST_RUN;
                end
            end
            mm_pkg::ST_ERR: begin
                if (out_free) begin
                    n_state = mm_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // State machine: outputs
    always_comb begin
        o_in_ready = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            mm_pkg::ST_IDLE: o_in_ready = 1'b1;
            mm_pkg::ST_RUN:  issue      = 1'b1;
            mm_pkg::ST_SUM:  out_load   = r_sum_ok && out_free;
            mm_pkg::ST_ERR:  out_load   = out_free;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the counters: k per issued term, j and i per element moved to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
        end else begin
            if (o_in_ready && in_fire && is_compute) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
            end
            if (issue) begin
                r_k <= k_last ? '0 : r_k + 1'b1;
            end
            if (out_load && r_state == mm_pkg::ST_SUM) begin
                if (j_last) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath: store read -> multiply -> accumulate
    // ---------------------------------------------------------------------
    logic r_v1, r_first1, r_last1;
    logic r_v2, r_first2, r_last2;
    logic signed [ProdW-1:0] r_prod;
    logic signed [63:0] prod_ext;
    logic [mm_pkg::PV_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_k == '0);
        r_last1  <= k_last;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_prod   <= signed'(rdata_a) * signed'(rdata_b);
    end

    // The sum wraps to the output field, so accumulate at that width
    assign prod_ext = 64'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_acc <= r_first2 ? prod_ext[mm_pkg::PV_W-1:0]
                              : r_acc + prod_ext[mm_pkg::PV_W-1:0];
        end
    end

    // Flag a finished sum; drop it when the element goes to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_ok <= 1'b0;
        end else if (r_v2 && r_last2) begin
            r_sum_ok <= 1'b1;
        end else if (out_load) begin
            r_sum_ok <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Output register: holds a result beat until taken, so the input side
    // can go back to idle while the final beat still waits.
    // ---------------------------------------------------------------------
    logic [mm_pkg::IDX_W-1:0] r_out_row, r_out_col;
    logic [mm_pkg::PV_W-1:0]  r_out_value;
    logic                     r_out_last, r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == mm_pkg::ST_ERR) begin
                r_out_row   <= '0;
                r_out_col   <= '0;
                r_out_value <= '0;
                r_out_last  <= 1'b1;
                r_out_err   <= 1'b1;
            end else begin
                r_out_row   <= r_i;
                r_out_col   <= r_j;
                r_out_value <= r_acc;
                r_out_last  <= i_last && j_last;
                r_out_err   <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = signed'(r_out_value);
    assign o_last          = r_out_last;
    assign o_dim_error     = r_out_err;

`ifndef ASSERT_OFF
    a_run_after_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_compute && ca == rb) |=> (r_state == mm_pkg::ST_RUN))
        else $error("compute beat with matching dimensions did not start a run");

    a_sum_only_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_ok |-> (r_state == mm_pkg::ST_SUM))
        else $error("finished sum outside the sum state");

    a_last_term_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_last2) |=> r_sum_ok)
        else $error("last term accumulated but sum not flagged");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dim_error) |-> o_last)
        else $error("dimension error beat not marked last");
`endif

endmodule

### sv/mm_ram.sv
// ---------------------------------------------------------------------------
// mm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mm_ram #(
    parameter int Width = 16,
    parameter int Depth = 64,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
